FILE: rtl/mrsr_pkg.sv
// Shared constants for the mask span-rectangle extractor.
// No dependencies; other files refer to this package by scoped names.
package mrsr_pkg;

    // Default coordinate width: columns and rows run from 0 to 2**COORD_BITS - 1.
    localparam int COORD_BITS_DEF = 12;

    // Batch counter and batch limit width.
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd2000;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LIMIT  = 2'd2;

    // Configuration data is as wide as the widest register.
    function automatic int cfg_data_width(input int coord_bits);
        return (coord_bits + 1 > COUNT_W) ? coord_bits + 1 : COUNT_W;
    endfunction

endpackage

FILE: rtl/mrsr_pixel_if.sv
// Input channel of the span extractor: one mask pixel per transfer.
// Depends on nothing beyond the valid/ready handshake it carries.
interface mrsr_pixel_if;
    logic valid;
    logic ready;
    logic pixel_set;

    modport source (output valid, output pixel_set, input ready);
    modport sink (input valid, input pixel_set, output ready);
endinterface

FILE: rtl/mrsr_rect_if.sv
// Result channel of the span extractor: one span rectangle and batch box per transfer.
// Field widths follow COORD_BITS; defaults come from mrsr_pkg.
interface mrsr_rect_if #(
    parameter int COORD_BITS = mrsr_pkg::COORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic                        rect_valid;
    logic [COORD_BITS-1:0]       rect_left;
    logic [COORD_BITS-1:0]       rect_row;
    logic [COORD_BITS:0]         rect_right;
    logic                        batch_end;
    logic                        image_end;
    logic [COORD_BITS:0]         bound_left;
    logic [COORD_BITS:0]         bound_top;
    logic [COORD_BITS:0]         bound_right;
    logic [COORD_BITS:0]         bound_bottom;
    logic [mrsr_pkg::COUNT_W-1:0] rects_in_batch;

    modport source (
        output valid, output rect_valid, output rect_left, output rect_row,
        output rect_right, output batch_end, output image_end, output bound_left,
        output bound_top, output bound_right, output bound_bottom,
        output rects_in_batch, input ready
    );
    modport sink (
        input valid, input rect_valid, input rect_left, input rect_row,
        input rect_right, input batch_end, input image_end, input bound_left,
        input bound_top, input bound_right, input bound_bottom,
        input rects_in_batch, output ready
    );
endinterface

FILE: rtl/mask_rows_to_span_rectangles.sv
// Mask span-rectangle extractor. Takes one mask pixel per cycle in row-major order, while
// the result buffer has room, and reports each horizontal run of opaque pixels as a one-row
// rectangle, together with the running batch bounding box and count; a result also marks the
// last pixel of the image. Between the position/box state registers and the result register
// the tracking logic is a handful of compares and increments; each result lands in the result
// register, or in the skid entry while that register is full. The result register plus the
// skid entry decouple the two sides, so pixels keep flowing while one result waits; the input
// only stalls once both are full. Configuration writes take effect on the next cycle.
// Depends on mrsr_pkg, mrsr_pixel_if, mrsr_rect_if, mrsr_cfg, mrsr_span and mrsr_out_buf.
module mask_rows_to_span_rectangles #(
    parameter int COORD_BITS = mrsr_pkg::COORD_BITS_DEF,
    parameter int CFG_W      = mrsr_pkg::cfg_data_width(COORD_BITS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mrsr_pixel_if.sink                     mask,
    mrsr_rect_if.source                    spans,
    input  logic                           cfg_we,
    input  logic [mrsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]               cfg_data
);

    localparam int BW    = COORD_BITS + 1;
    localparam int RES_W = 3 + 2 * COORD_BITS + 5 * BW + mrsr_pkg::COUNT_W;

    logic [COORD_BITS-1:0]        last_col;
    logic [COORD_BITS-1:0]        last_row;
    logic [mrsr_pkg::COUNT_W-1:0] limit;

    logic                         step;
    logic                         has_result;
    logic                         rect_valid;
    logic [COORD_BITS-1:0]        rect_left;
    logic [COORD_BITS-1:0]        rect_row;
    logic [BW-1:0]                rect_right;
    logic                         batch_end;
    logic                         image_end;
    logic [BW-1:0]                bound_left;
    logic [BW-1:0]                bound_top;
    logic [BW-1:0]                bound_right;
    logic [BW-1:0]                bound_bottom;
    logic [mrsr_pkg::COUNT_W-1:0] rects_in_batch;

    logic [RES_W-1:0]             res_in;
    logic [RES_W-1:0]             res_out;
    logic                         buf_ready;

    mrsr_cfg #(
        .COORD_BITS (COORD_BITS),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .last_col  (last_col),
        .last_row  (last_row),
        .limit     (limit)
    );

    assign mask.ready = buf_ready;
    assign step       = mask.valid && buf_ready;

    mrsr_span #(
        .COORD_BITS (COORD_BITS)
    ) u_span (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .pixel_set      (mask.pixel_set),
        .last_col       (last_col),
        .last_row       (last_row),
        .limit          (limit),
        .has_result     (has_result),
        .rect_valid     (rect_valid),
        .rect_left      (rect_left),
        .rect_row       (rect_row),
        .rect_right     (rect_right),
        .batch_end      (batch_end),
        .image_end      (image_end),
        .bound_left     (bound_left),
        .bound_top      (bound_top),
        .bound_right    (bound_right),
        .bound_bottom   (bound_bottom),
        .rects_in_batch (rects_in_batch)
    );

    assign res_in = {rect_valid, rect_left, rect_row, rect_right, batch_end, image_end,
                     bound_left, bound_top, bound_right, bound_bottom, rects_in_batch};

    mrsr_out_buf #(
        .WIDTH (RES_W)
    ) u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step && has_result),
        .push_data  (res_in),
        .push_ready (buf_ready),
        .out_valid  (spans.valid),
        .out_ready  (spans.ready),
        .out_data   (res_out)
    );

    assign {spans.rect_valid, spans.rect_left, spans.rect_row, spans.rect_right,
            spans.batch_end, spans.image_end, spans.bound_left, spans.bound_top,
            spans.bound_right, spans.bound_bottom, spans.rects_in_batch} = res_out;

endmodule

FILE: rtl/mrsr_cfg.sv
// Configuration registers of the span extractor.
// Stores the last column, last row and effective batch limit, clamped at write time.
module mrsr_cfg #(
    parameter int COORD_BITS = mrsr_pkg::COORD_BITS_DEF,
    parameter int CFG_W      = mrsr_pkg::cfg_data_width(COORD_BITS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mrsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data,
    output logic [COORD_BITS-1:0]            last_col,
    output logic [COORD_BITS-1:0]            last_row,
    output logic [mrsr_pkg::COUNT_W-1:0]     limit
);

    localparam int DIM_W = COORD_BITS + 1;
    localparam logic [DIM_W-1:0] SPAN = DIM_W'(1) << COORD_BITS;

    logic [DIM_W-1:0]              dim;
    logic [DIM_W-1:0]              dim_m1;
    logic [COORD_BITS-1:0]         last_idx;
    logic [mrsr_pkg::COUNT_W-1:0]  lim_in;
    logic [COORD_BITS-1:0]         last_col_reg, last_col_next;
    logic [COORD_BITS-1:0]         last_row_reg, last_row_next;
    logic [mrsr_pkg::COUNT_W-1:0]  limit_reg, limit_next;

    // A dimension of zero acts as one, and one beyond the coordinate range acts as the range.
    assign dim    = cfg_data[DIM_W-1:0];
    assign dim_m1 = dim - DIM_W'(1);
    assign lim_in = cfg_data[mrsr_pkg::COUNT_W-1:0];

    always_comb
    begin
        if (dim == '0)
        begin
            last_idx = '0;
        end
        else if (dim > SPAN)
        begin
            last_idx = '1;
        end
        else
        begin
            last_idx = dim_m1[COORD_BITS-1:0];
        end
    end

    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        limit_next    = limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mrsr_pkg::CFG_IMAGE_WIDTH:  last_col_next = last_idx;
                mrsr_pkg::CFG_IMAGE_HEIGHT: last_row_next = last_idx;
                mrsr_pkg::CFG_BATCH_LIMIT:
                begin
                    limit_next = (lim_in == '0) ? mrsr_pkg::COUNT_W'(1) : lim_in;
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= '0;
            last_row_reg <= '0;
            limit_reg    <= mrsr_pkg::LIMIT_RESET;
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            limit_reg    <= limit_next;
        end
    end

    assign last_col = last_col_reg;
    assign last_row = last_row_reg;
    assign limit    = limit_reg;

endmodule

FILE: rtl/mrsr_span.sv
// Span tracking core: position, open run, batch bounding box and count.
// Produces one result per pixel transfer that closes a run or ends the image.
module mrsr_span #(
    parameter int COORD_BITS = mrsr_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          pixel_set,
    input  logic [COORD_BITS-1:0]         last_col,
    input  logic [COORD_BITS-1:0]         last_row,
    input  logic [mrsr_pkg::COUNT_W-1:0]  limit,
    output logic                          has_result,
    output logic                          rect_valid,
    output logic [COORD_BITS-1:0]         rect_left,
    output logic [COORD_BITS-1:0]         rect_row,
    output logic [COORD_BITS:0]           rect_right,
    output logic                          batch_end,
    output logic                          image_end,
    output logic [COORD_BITS:0]           bound_left,
    output logic [COORD_BITS:0]           bound_top,
    output logic [COORD_BITS:0]           bound_right,
    output logic [COORD_BITS:0]           bound_bottom,
    output logic [mrsr_pkg::COUNT_W-1:0]  rects_in_batch
);

    localparam int BW = COORD_BITS + 1;
    localparam logic [BW-1:0] SPAN = BW'(1) << COORD_BITS;

    logic [COORD_BITS-1:0]        col_reg, col_next;
    logic [COORD_BITS-1:0]        row_reg, row_next;
    logic                         open_reg, open_next;
    logic [COORD_BITS-1:0]        start_reg, start_next;
    logic [BW-1:0]                left_reg, left_next;
    logic [BW-1:0]                top_reg, top_next;
    logic [BW-1:0]                right_reg, right_next;
    logic [BW-1:0]                bottom_reg, bottom_next;
    logic [mrsr_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                         at_last_col;
    logic                         at_last_row;
    logic                         img_end;
    logic                         rect;
    logic [COORD_BITS-1:0]        span_left;
    logic [BW-1:0]                span_right;
    logic [BW-1:0]                row_ext;
    logic [BW-1:0]                row_below;
    logic [BW-1:0]                box_left;
    logic [BW-1:0]                box_top;
    logic [BW-1:0]                box_right;
    logic [BW-1:0]                box_bottom;
    logic [mrsr_pkg::COUNT_W-1:0] count_inc;
    logic                         bend;

    // A position left past the last column or row by a smaller mid-image size counts as the last.
    assign at_last_col = col_reg >= last_col;
    assign at_last_row = row_reg >= last_row;
    assign img_end     = at_last_col && at_last_row;

    assign rect       = pixel_set ? at_last_col : open_reg;
    assign span_left  = open_reg ? start_reg : col_reg;
    assign span_right = {1'b0, col_reg} + (pixel_set ? BW'(1) : BW'(0));
    assign row_ext    = {1'b0, row_reg};
    assign row_below  = row_ext + BW'(1);

    assign box_left   = ({1'b0, span_left} < left_reg) ? {1'b0, span_left} : left_reg;
    assign box_top    = (row_ext < top_reg) ? row_ext : top_reg;
    assign box_right  = (span_right > right_reg) ? span_right : right_reg;
    assign box_bottom = (row_below > bottom_reg) ? row_below : bottom_reg;
    assign count_inc  = count_reg + mrsr_pkg::COUNT_W'(1);
    assign bend       = rect && (count_inc >= limit);

    assign has_result     = rect || img_end;
    assign rect_valid     = rect;
    assign rect_left      = rect ? span_left : '0;
    assign rect_row       = rect ? row_reg : '0;
    assign rect_right     = rect ? span_right : '0;
    assign batch_end      = bend;
    assign image_end      = img_end;
    assign bound_left     = rect ? box_left : left_reg;
    assign bound_top      = rect ? box_top : top_reg;
    assign bound_right    = rect ? box_right : right_reg;
    assign bound_bottom   = rect ? box_bottom : bottom_reg;
    assign rects_in_batch = rect ? count_inc : count_reg;

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        open_next   = open_reg;
        start_next  = start_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        count_next  = count_reg;
        if (step)
        begin
            open_next = pixel_set && !at_last_col;
            if (pixel_set && !open_reg)
            begin
                start_next = col_reg;
            end

            if (bend || img_end)
            begin
                left_next   = SPAN;
                top_next    = SPAN;
                right_next  = '0;
                bottom_next = '0;
                count_next  = '0;
            end
            else if (rect)
            begin
                left_next   = box_left;
                top_next    = box_top;
                right_next  = box_right;
                bottom_next = box_bottom;
                count_next  = count_inc;
            end

            if (at_last_col)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_below[COORD_BITS-1:0];
            end
            else
            begin
                col_next = col_reg + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            open_reg   <= 1'b0;
            start_reg  <= '0;
            left_reg   <= SPAN;
            top_reg    <= SPAN;
            right_reg  <= '0;
            bottom_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            open_reg   <= open_next;
            start_reg  <= start_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/mrsr_out_buf.sv
// Result register with a skid entry; the input side is held only while the skid entry is occupied.
// Generic over the payload width; no package dependencies.
module mrsr_out_buf #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [WIDTH-1:0] main_data_reg, main_data_next;
    logic [WIDTH-1:0] skid_data_reg, skid_data_next;
    logic             pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // No push can arrive while the skid entry is occupied.
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule
